FILE: hdl/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Shared assertion macros for the checker files.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion, live during reset as well
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/mpr_pkg.sv
// ============================================================================
// mpr_pkg
// Widths, register map, reset values and shared types for the mask pixel
// to RGB24 converter.
// ============================================================================
package mpr_pkg;

    localparam int RAW_W          = 32;
    localparam int CH_W           = 8;
    localparam int CFG_W          = 32;
    localparam int ADDR_W         = 4;
    localparam int REG_IDX_W      = 2;
    localparam int NUM_CH         = 3;
    localparam int PIXEL_BITS_DEF = 32;

    localparam int EXT_STAGES = 3;
    localparam int NUM_STAGES = EXT_STAGES + CH_W;

    localparam logic [REG_IDX_W-1:0] REG_RED   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_GREEN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BLUE  = 2'd2;

    localparam logic [CFG_W-1:0] RESET_RED   = 32'h00ff_0000;
    localparam logic [CFG_W-1:0] RESET_GREEN = 32'h0000_ff00;
    localparam logic [CFG_W-1:0] RESET_BLUE  = 32'h0000_00ff;

    typedef struct packed {
        logic [CFG_W-1:0] red;
        logic [CFG_W-1:0] green;
        logic [CFG_W-1:0] blue;
    } t_mask_cfg;

endpackage

FILE: hdl/mpr_if.sv
// ============================================================================
// mpr_if
// Valid/ready stream interfaces: raw pixel words in, RGB24 words out.
// ============================================================================
interface mpr_pix_if;
    logic                        valid;
    logic                        ready;
    logic [mpr_pkg::RAW_W-1:0]   raw_pixel;

    modport source (output valid, output raw_pixel, input ready);
    modport sink   (input valid, input raw_pixel, output ready);
endinterface

interface mpr_rgb_if;
    logic                        valid;
    logic                        ready;
    logic [mpr_pkg::CH_W-1:0]    red_out;
    logic [mpr_pkg::CH_W-1:0]    green_out;
    logic [mpr_pkg::CH_W-1:0]    blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

FILE: hdl/mpr_cfg.sv
// ============================================================================
// mpr_cfg
// APB register file holding the three channel masks.
// ============================================================================
module mpr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mpr_pkg::ADDR_W-1:0]    paddr,
    input  logic [mpr_pkg::CFG_W-1:0]     pwdata,
    output logic [mpr_pkg::CFG_W-1:0]     prdata,
    output logic                          pready,
    output mpr_pkg::t_mask_cfg            o_cfg
);

    mpr_pkg::t_mask_cfg                  r_cfg;
    logic [mpr_pkg::REG_IDX_W-1:0]       w_idx;

    assign w_idx  = paddr[mpr_pkg::ADDR_W-1:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red   <= mpr_pkg::RESET_RED;
            r_cfg.green <= mpr_pkg::RESET_GREEN;
            r_cfg.blue  <= mpr_pkg::RESET_BLUE;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                mpr_pkg::REG_RED:   r_cfg.red   <= pwdata;
                mpr_pkg::REG_GREEN: r_cfg.green <= pwdata;
                mpr_pkg::REG_BLUE:  r_cfg.blue  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            mpr_pkg::REG_RED:   prdata = r_cfg.red;
            mpr_pkg::REG_GREEN: prdata = r_cfg.green;
            mpr_pkg::REG_BLUE:  prdata = r_cfg.blue;
            default:            prdata = '0;
        endcase
    end

endmodule

FILE: hdl/mpr_pipe_ctrl.sv
// ============================================================================
// mpr_pipe_ctrl
// Valid bits and per-stage load enables; a stage advances when it is empty
// or the stage after it advances, so bubbles collapse under stall.
// ============================================================================
module mpr_pipe_ctrl #(
    parameter int N = mpr_pkg::NUM_STAGES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [N-1:0]  o_load
);

    logic [N-1:0] r_vld;
    logic [N:0]   w_rdy;

    always_comb begin
        w_rdy[N] = i_out_ready;
        for (int k = N - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_load      = w_rdy[N-1:0];
    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < N; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

endmodule

FILE: hdl/mpr_extract.sv
// ============================================================================
// mpr_extract
// Three stages per channel: trailing-zero count of the mask, shift of mask
// and field down to bit zero, and field*255 as the dividend.
// ============================================================================
module mpr_extract #(
    parameter int W = mpr_pkg::RAW_W
) (
    input  logic                                    i_clk,
    input  logic [mpr_pkg::EXT_STAGES-1:0]          i_load,
    input  logic [W-1:0]                            i_pixel,
    input  logic [W-1:0]                            i_mask,
    output logic [W+mpr_pkg::CH_W-1:0]              o_rem,
    output logic [W-1:0]                            o_div
);

    localparam int SH_W = $clog2(W);
    localparam int RW   = W + mpr_pkg::CH_W;

    logic [W-1:0]    w_lsb;
    logic [SH_W-1:0] n0_sh;
    logic [SH_W-1:0] r0_sh;
    logic [W-1:0]    r0_fld;
    logic [W-1:0]    r0_mask;
    logic [W-1:0]    r1_top;
    logic [W-1:0]    r1_fld;
    logic            w_zero;
    logic [RW-1:0]   w_fld_ext;
    logic [RW-1:0]   r2_rem;
    logic [W-1:0]    r2_div;

    assign w_lsb = i_mask & (~i_mask + W'(1));

    always_comb begin
        n0_sh = '0;
        for (int i = 0; i < W; i++) begin
            n0_sh = n0_sh | (w_lsb[i] ? SH_W'(i) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r0_sh   <= n0_sh;
            r0_fld  <= i_pixel & i_mask;
            r0_mask <= i_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r1_top <= r0_mask >> r0_sh;
            r1_fld <= r0_fld >> r0_sh;
        end
    end

    // zero mask: empty dividend over an all-ones divisor gives a zero quotient
    assign w_zero    = (r1_top == '0);
    assign w_fld_ext = RW'(r1_fld);

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r2_rem <= w_zero ? '0 : ((w_fld_ext << mpr_pkg::CH_W) - w_fld_ext);
            r2_div <= w_zero ? '1 : r1_top;
        end
    end

    assign o_rem = r2_rem;
    assign o_div = r2_div;

endmodule

FILE: hdl/mpr_div_step.sv
// ============================================================================
// mpr_div_step
// One registered restoring-division step, yielding one quotient bit.
// ============================================================================
module mpr_div_step #(
    parameter int W   = mpr_pkg::RAW_W,
    parameter int BIT = 0
) (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  logic [W+mpr_pkg::CH_W-1:0]      i_rem,
    input  logic [W-1:0]                    i_div,
    input  logic [mpr_pkg::CH_W-1:0]        i_q,
    output logic [W+mpr_pkg::CH_W-1:0]      o_rem,
    output logic [W-1:0]                    o_div,
    output logic [mpr_pkg::CH_W-1:0]        o_q
);

    localparam int RW = W + mpr_pkg::CH_W;

    logic [RW-1:0]              w_dsh;
    logic                       w_ge;
    logic [mpr_pkg::CH_W-1:0]   n_q;
    logic [RW-1:0]              r_rem;
    logic [W-1:0]               r_div;
    logic [mpr_pkg::CH_W-1:0]   r_q;

    assign w_dsh = RW'(i_div) << BIT;
    assign w_ge  = (i_rem >= w_dsh);

    always_comb begin
        n_q      = i_q;
        n_q[BIT] = w_ge;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= w_ge ? (i_rem - w_dsh) : i_rem;
            r_div <= i_div;
            r_q   <= n_q;
        end
    end

    assign o_rem = r_rem;
    assign o_div = r_div;
    assign o_q   = r_q;

endmodule

FILE: hdl/mask_pixel_to_rgb24.sv
// ============================================================================
// mask_pixel_to_rgb24
// Converts raw pixel words to 8-bit red, green and blue through three
// configurable channel masks, rescaling each field as field*255/max.
// ============================================================================
//
//  port     dir  width                 word
//  i_pix    in   32 (raw_pixel)        one raw pixel
//  o_rgb    out  3 x 8 (red/green/     one RGB24 triple
//                blue_out)
//  APB      in   32 data, 4 addr       channel mask registers at 0x0, 0x4, 0x8
//
//  One word per cycle sustained while the output is not stalled; 3 extract
//  stages per channel, then 8 registered division steps, one quotient bit each.
//  Reset clears all valid bits and loads the standard 8:8:8 masks.
//  A stall holds every full stage in place; empty stages keep filling behind it.
//
module mask_pixel_to_rgb24 #(
    parameter int PIXEL_BITS = mpr_pkg::PIXEL_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mpr_pix_if.sink                       i_pix,
    mpr_rgb_if.source                     o_rgb,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mpr_pkg::ADDR_W-1:0]    paddr,
    input  logic [mpr_pkg::CFG_W-1:0]     pwdata,
    output logic [mpr_pkg::CFG_W-1:0]     prdata,
    output logic                          pready
);

    localparam int LANE_W = (PIXEL_BITS < mpr_pkg::RAW_W) ? PIXEL_BITS : mpr_pkg::RAW_W;
    localparam int RW     = LANE_W + mpr_pkg::CH_W;
    localparam int NS     = mpr_pkg::NUM_STAGES;
    localparam int ES     = mpr_pkg::EXT_STAGES;

    mpr_pkg::t_mask_cfg              w_cfg;
    logic [NS-1:0]                   w_load;
    logic [LANE_W-1:0]               w_mask [mpr_pkg::NUM_CH];
    logic [mpr_pkg::CH_W-1:0]        w_chan [mpr_pkg::NUM_CH];

    mpr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mpr_pipe_ctrl #(.N(NS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (i_pix.ready),
        .i_out_ready (o_rgb.ready),
        .o_out_valid (o_rgb.valid),
        .o_load      (w_load)
    );

    assign w_mask[0] = w_cfg.red[LANE_W-1:0];
    assign w_mask[1] = w_cfg.green[LANE_W-1:0];
    assign w_mask[2] = w_cfg.blue[LANE_W-1:0];

    for (genvar c = 0; c < mpr_pkg::NUM_CH; c++) begin : g_lane
        logic [RW-1:0]              w_rem [mpr_pkg::CH_W];
        logic [LANE_W-1:0]          w_div [mpr_pkg::CH_W];
        logic [mpr_pkg::CH_W-1:0]   w_q   [mpr_pkg::CH_W];

        mpr_extract #(.W(LANE_W)) u_ext (
            .i_clk   (i_clk),
            .i_load  (w_load[ES-1:0]),
            .i_pixel (i_pix.raw_pixel[LANE_W-1:0]),
            .i_mask  (w_mask[c]),
            .o_rem   (w_rem[0]),
            .o_div   (w_div[0])
        );

        assign w_q[0] = '0;

        for (genvar j = 0; j < mpr_pkg::CH_W; j++) begin : g_step
            if (j < mpr_pkg::CH_W - 1) begin : g_mid
                mpr_div_step #(.W(LANE_W), .BIT(mpr_pkg::CH_W - 1 - j)) u_step (
                    .i_clk  (i_clk),
                    .i_load (w_load[ES+j]),
                    .i_rem  (w_rem[j]),
                    .i_div  (w_div[j]),
                    .i_q    (w_q[j]),
                    .o_rem  (w_rem[j+1]),
                    .o_div  (w_div[j+1]),
                    .o_q    (w_q[j+1])
                );
            end else begin : g_last
                mpr_div_step #(.W(LANE_W), .BIT(mpr_pkg::CH_W - 1 - j)) u_step (
                    .i_clk  (i_clk),
                    .i_load (w_load[ES+j]),
                    .i_rem  (w_rem[j]),
                    .i_div  (w_div[j]),
                    .i_q    (w_q[j]),
                    .o_rem  (),
                    .o_div  (),
                    .o_q    (w_chan[c])
                );
            end
        end
    end

    assign o_rgb.red_out   = w_chan[0];
    assign o_rgb.green_out = w_chan[1];
    assign o_rgb.blue_out  = w_chan[2];

endmodule

FILE: hdl/mpr_checker.sv
// ============================================================================
// mpr_checker
// Port-level checks on the converter's stream handshakes, bound to the top.
// ============================================================================
`include "assert_macros.svh"

module mpr_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [mpr_pkg::CH_W-1:0]   i_red,
    input  logic [mpr_pkg::CH_W-1:0]   i_green,
    input  logic [mpr_pkg::CH_W-1:0]   i_blue
);

    `ASSERT_CLK_NR(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "output word valid after reset")
    `ASSERT_CLK(a_empty_out_ready, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "input stalled with empty output")
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_red) && $stable(i_green) && $stable(i_blue), "stalled output word changed")
    `ASSERT_CLK(a_idle_input, i_clk, i_rst_n, !i_in_valid && !i_out_valid |=> !$rose(i_out_valid) || $past(i_in_ready), "output word from nowhere")

endmodule

bind mask_pixel_to_rgb24 mpr_checker u_mpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red_out),
    .i_green     (o_rgb.green_out),
    .i_blue      (o_rgb.blue_out)
);
